### rtl/assert_macros.svh
// assertion macros used by the cbor_item_head_encoder rtl
// no dependencies; each macro clocks on the given clock with an active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define AST_HOLD(label, clk_i, rst_n_i, prop, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (prop)) else $error(msg);

// condition in one cycle implies a property in the next
`define AST_NEXT(label, clk_i, rst_n_i, pre, post, msg) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (pre) |=> (post)) \
		else $error(msg);

`endif

### rtl/cbih_pkg.sv
// cbor head encoder package: mode codes, item kinds and encoding constants
// no dependencies
package cbih_pkg;

	localparam int unsigned MODE_W = 4;
	localparam int unsigned VALUE_W = 64;
	localparam int unsigned MAX_BYTES = 9;
	localparam int unsigned CNT_W = 4;
	localparam int unsigned BUF_W = 8 * MAX_BYTES;

	localparam logic [MODE_W-1:0] MODE_UINT    = 4'd0;
	localparam logic [MODE_W-1:0] MODE_SINT    = 4'd1;
	localparam logic [MODE_W-1:0] MODE_BOOL    = 4'd2;
	localparam logic [MODE_W-1:0] MODE_FLOAT32 = 4'd3;
	localparam logic [MODE_W-1:0] MODE_FLOAT64 = 4'd4;
	localparam logic [MODE_W-1:0] MODE_BYTES   = 4'd5;
	localparam logic [MODE_W-1:0] MODE_TEXT    = 4'd6;
	localparam logic [MODE_W-1:0] MODE_MAP     = 4'd7;
	localparam logic [MODE_W-1:0] MODE_ARRAY   = 4'd8;
	localparam logic [MODE_W-1:0] MODE_PAYLOAD = 4'd9;

	localparam logic [2:0] MAJOR_UINT  = 3'd0;
	localparam logic [2:0] MAJOR_NINT  = 3'd1;
	localparam logic [2:0] MAJOR_BYTES = 3'd2;
	localparam logic [2:0] MAJOR_TEXT  = 3'd3;
	localparam logic [2:0] MAJOR_ARRAY = 3'd4;
	localparam logic [2:0] MAJOR_MAP   = 3'd5;

	localparam logic [63:0] INLINE_LIMIT = 64'd24;
	localparam logic [4:0]  AI_ARG8      = 5'd24;
	localparam logic [4:0]  AI_ARG16     = 5'd25;
	localparam logic [4:0]  AI_ARG32     = 5'd26;
	localparam logic [4:0]  AI_ARG64     = 5'd27;

	localparam logic [7:0] SIMPLE_FALSE = 8'hF4;
	localparam logic [7:0] FLOAT32_HEAD = 8'hFA;
	localparam logic [7:0] FLOAT64_HEAD = 8'hFB;

	localparam logic [10:0] EXP_MAX       = 11'h7FF;
	localparam logic [10:0] EXP_F32_NORM  = 11'd897;
	localparam logic [10:0] EXP_F32_TOP   = 11'd1150;
	localparam logic [10:0] EXP_F32_SUB   = 11'd874;
	localparam logic [10:0] EXP_REBIAS    = 11'd896;
	localparam logic [10:0] EXP_SUB_SHIFT = 11'd926;
	localparam logic [31:0] F32_INF       = 32'h7F80_0000;

	typedef enum logic [2:0] {
		KIND_NONE,
		KIND_HEAD,
		KIND_BOOL,
		KIND_F32,
		KIND_F64,
		KIND_PAY
	} kind_t;

endpackage

### rtl/cbor_item_head_encoder.sv
// cbor item head encoder top level: three-stage encode pipeline and byte serializer
// depends on cbih_pkg and assert_macros.svh
//
// channel   direction  signals                          per transaction
// item      in         item_valid item_ready mode value one item to encode
// byte      out        byte_valid byte_ready out_byte   one encoded byte, last_byte on final
//
// an item passes three register stages, then the serializer emits 1 to 9 bytes
// one byte per cycle while byte_ready is high; a payload item gives a single byte
// with no stall an item goes through stages 1, 2, 3, then the serializer shows its first byte
// reset clears all valid bits; items of unused modes give no bytes and are dropped
// byte_ready low stalls the serializer and the stages behind it without loss
`include "assert_macros.svh"

module cbor_item_head_encoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [cbih_pkg::MODE_W-1:0]   mode,
	input  logic [cbih_pkg::VALUE_W-1:0]  value,
	output logic                          byte_valid,
	input  logic                          byte_ready,
	output logic [7:0]                    out_byte,
	output logic                          last_byte
);
	import cbih_pkg::*;

	// stage 1: kind, major type, argument
	logic               v_s1;
	kind_t              kind_s1;
	logic [2:0]         major_s1;
	logic [VALUE_W-1:0] arg_s1;

	// stage 2: argument size, float shrink
	logic               v_s2;
	kind_t              kind_s2;
	logic [2:0]         major_s2;
	logic [VALUE_W-1:0] arg_s2;
	logic [4:0]         ai_s2;
	logic [3:0]         nb_s2;
	logic               shrink_s2;
	logic [31:0]        f32_s2;

	// stage 3: byte buffer
	logic               v_s3;
	logic [BUF_W-1:0]   buf_s3;
	logic [CNT_W-1:0]   cnt_s3;

	// serializer
	logic               sv_q;
	logic [BUF_W-1:0]   buf_q;
	logic [CNT_W-1:0]   cnt_q;

	logic adv1, adv2, adv3, take;
	logic byte_done;

	assign byte_done = sv_q && byte_ready;
	assign take = v_s3 && (!sv_q || (byte_done && last_byte));
	assign adv3 = !v_s3 || take;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign item_ready = adv1;

	// stage 1 decode
	kind_t              kind_d1;
	logic [2:0]         major_d1;
	logic [VALUE_W-1:0] arg_d1;

	always_comb begin
		kind_d1 = KIND_HEAD;
		major_d1 = MAJOR_UINT;
		arg_d1 = value;
		unique case (mode)
			MODE_UINT: major_d1 = MAJOR_UINT;
			MODE_SINT: begin
				if (value[VALUE_W-1]) begin
					major_d1 = MAJOR_NINT;
					arg_d1 = ~value;
				end
			end
			MODE_BOOL:    kind_d1 = KIND_BOOL;
			MODE_FLOAT32: kind_d1 = KIND_F32;
			MODE_FLOAT64: kind_d1 = KIND_F64;
			MODE_BYTES:   major_d1 = MAJOR_BYTES;
			MODE_TEXT:    major_d1 = MAJOR_TEXT;
			MODE_MAP:     major_d1 = MAJOR_MAP;
			MODE_ARRAY:   major_d1 = MAJOR_ARRAY;
			MODE_PAYLOAD: kind_d1 = KIND_PAY;
			default:      kind_d1 = KIND_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			kind_s1 <= kind_d1;
			major_s1 <= major_d1;
			arg_s1 <= arg_d1;
		end
	end

	// stage 2: argument class and float64 to float32 test
	logic [4:0]  ai_d2;
	logic [3:0]  nb_d2;
	logic        shrink_d2;
	logic [31:0] f32_d2;
	logic [10:0] exp_d2;
	logic [51:0] man_d2;
	logic [52:0] full_d2;
	logic [52:0] mask_d2;
	logic [52:0] sub_d2;
	logic [10:0] sh_d2;
	logic [10:0] rebias_d2;

	always_comb begin
		if (arg_s1 < INLINE_LIMIT) begin
			ai_d2 = arg_s1[4:0];
			nb_d2 = 4'd0;
		end else if (arg_s1[63:8] == '0) begin
			ai_d2 = AI_ARG8;
			nb_d2 = 4'd1;
		end else if (arg_s1[63:16] == '0) begin
			ai_d2 = AI_ARG16;
			nb_d2 = 4'd2;
		end else if (arg_s1[63:32] == '0) begin
			ai_d2 = AI_ARG32;
			nb_d2 = 4'd4;
		end else begin
			ai_d2 = AI_ARG64;
			nb_d2 = 4'd8;
		end
	end

	always_comb begin
		exp_d2 = arg_s1[62:52];
		man_d2 = arg_s1[51:0];
		full_d2 = {1'b1, man_d2};
		sh_d2 = EXP_SUB_SHIFT - exp_d2;
		mask_d2 = (53'd1 << sh_d2[5:0]) - 53'd1;
		sub_d2 = full_d2 >> sh_d2[5:0];
		rebias_d2 = exp_d2 - EXP_REBIAS;
		shrink_d2 = 1'b0;
		f32_d2 = {arg_s1[63], 31'd0};
		if (exp_d2 == EXP_MAX) begin
			shrink_d2 = (man_d2 == '0);
			f32_d2 = {arg_s1[63], 31'd0} | F32_INF;
		end else if (exp_d2 == '0) begin
			shrink_d2 = (man_d2 == '0);
		end else if (exp_d2 >= EXP_F32_NORM && exp_d2 <= EXP_F32_TOP) begin
			shrink_d2 = (man_d2[28:0] == '0);
			f32_d2 = {arg_s1[63], rebias_d2[7:0], man_d2[51:29]};
		end else if (exp_d2 >= EXP_F32_SUB && exp_d2 < EXP_F32_NORM) begin
			shrink_d2 = ((full_d2 & mask_d2) == '0);
			f32_d2 = {arg_s1[63], 8'd0, sub_d2[22:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			kind_s2 <= kind_s1;
			major_s2 <= major_s1;
			arg_s2 <= arg_s1;
			ai_s2 <= ai_d2;
			nb_s2 <= nb_d2;
			shrink_s2 <= shrink_d2;
			f32_s2 <= f32_d2;
		end
	end

	// stage 3: byte buffer, first byte in the top lane
	logic [7:0]         b0_d3;
	logic [VALUE_W-1:0] tail_d3;
	logic [CNT_W-1:0]   cnt_d3;

	always_comb begin
		b0_d3 = '0;
		tail_d3 = '0;
		cnt_d3 = '0;
		case (kind_s2)
			KIND_HEAD: begin
				b0_d3 = {major_s2, ai_s2};
				cnt_d3 = nb_s2 + 4'd1;
				case (nb_s2)
					4'd1:    tail_d3 = {arg_s2[7:0], 56'd0};
					4'd2:    tail_d3 = {arg_s2[15:0], 48'd0};
					4'd4:    tail_d3 = {arg_s2[31:0], 32'd0};
					4'd8:    tail_d3 = arg_s2;
					default: tail_d3 = '0;
				endcase
			end
			KIND_BOOL: begin
				b0_d3 = SIMPLE_FALSE | {7'd0, arg_s2[0]};
				cnt_d3 = 4'd1;
			end
			KIND_F32: begin
				b0_d3 = FLOAT32_HEAD;
				tail_d3 = {arg_s2[31:0], 32'd0};
				cnt_d3 = 4'd5;
			end
			KIND_F64: begin
				if (shrink_s2) begin
					b0_d3 = FLOAT32_HEAD;
					tail_d3 = {f32_s2, 32'd0};
					cnt_d3 = 4'd5;
				end else begin
					b0_d3 = FLOAT64_HEAD;
					tail_d3 = arg_s2;
					cnt_d3 = 4'd9;
				end
			end
			KIND_PAY: begin
				b0_d3 = arg_s2[7:0];
				cnt_d3 = 4'd1;
			end
			default: cnt_d3 = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv3) begin
			v_s3 <= v_s2 && (cnt_d3 != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			buf_s3 <= {b0_d3, tail_d3};
			cnt_s3 <= cnt_d3;
		end
	end

	// serializer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_q <= 1'b0;
			cnt_q <= '0;
		end else if (take) begin
			sv_q <= 1'b1;
			cnt_q <= cnt_s3;
		end else if (byte_done) begin
			cnt_q <= cnt_q - 4'd1;
			if (last_byte) begin
				sv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			buf_q <= buf_s3;
		end else if (byte_done) begin
			buf_q <= {buf_q[BUF_W-9:0], 8'd0};
		end
	end

	assign byte_valid = sv_q;
	assign out_byte = buf_q[BUF_W-1 -: 8];
	assign last_byte = (cnt_q == 4'd1);

	`AST_HOLD(a_ser_count, clk, arst_n, !sv_q || (cnt_q != '0 && cnt_q <= 4'd9), "serializer count out of range")
	`AST_HOLD(a_s3_count, clk, arst_n, !v_s3 || (cnt_s3 != '0 && cnt_s3 <= 4'd9), "stage 3 holds an empty item")
	`AST_NEXT(a_ser_cont, clk, arst_n, byte_done && !last_byte, byte_valid, "item dropped before its last byte")
	`AST_NEXT(a_s3_hold, clk, arst_n, v_s3 && !take, v_s3 && $stable(buf_s3) && $stable(cnt_s3), "stalled stage 3 lost its item")

endmodule

### tb/cbor_item_head_encoder_tb.sv
`timescale 1ns / 100ps
// testbench for cbor_item_head_encoder: directed and random items checked byte by byte
// against a behavioral encoder of cbor heads, floats and payload bytes
// depends on cbih_pkg and the cbor_item_head_encoder rtl
module cbor_item_head_encoder_tb;
	import cbih_pkg::*;

	localparam int HALF_PERIOD = 10;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_ITEMS = 80;
	localparam logic [MODE_W-1:0] MODE_RESERVED_A = 4'd10;
	localparam logic [MODE_W-1:0] MODE_RESERVED_Z = 4'd15;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} enc_byte_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_ready;
	logic [MODE_W-1:0]  mode = '0;
	logic [VALUE_W-1:0] value = '0;
	logic               byte_valid;
	logic               byte_ready = 1'b0;
	logic [7:0]         out_byte;
	logic               last_byte;

	enc_byte_t  expected_q[$];
	logic [7:0] item_bytes[$];
	int         mismatches = 0;
	int         cycle_count = 0;
	int         stall_left = 0;
	bit         steady = 1'b0;

	cbor_item_head_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.mode       (mode),
		.value      (value),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.out_byte   (out_byte),
		.last_byte  (last_byte)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic void put_be(input logic [63:0] v, input int n);
		for (int i = n - 1; i >= 0; i--)
			item_bytes.push_back(v[8*i +: 8]);
	endfunction

	function automatic void put_head(input logic [2:0] major, input logic [63:0] arg);
		if (arg < INLINE_LIMIT) begin
			item_bytes.push_back({major, arg[4:0]});
		end else if (arg <= 64'hFF) begin
			item_bytes.push_back({major, AI_ARG8});
			put_be(arg, 1);
		end else if (arg <= 64'hFFFF) begin
			item_bytes.push_back({major, AI_ARG16});
			put_be(arg, 2);
		end else if (arg <= 64'hFFFF_FFFF) begin
			item_bytes.push_back({major, AI_ARG32});
			put_be(arg, 4);
		end else begin
			item_bytes.push_back({major, AI_ARG64});
			put_be(arg, 8);
		end
	endfunction

	function automatic bit f64_to_f32(input logic [63:0] d, output logic [31:0] f);
		logic [10:0] e;
		logic [51:0] m;
		logic [52:0] full;
		int          ex;
		int          sh;
		e = d[62:52];
		m = d[51:0];
		f = {d[63], 31'd0};
		if (e == EXP_MAX) begin
			f = f | F32_INF;
			return m == '0;
		end
		if (e == '0)
			return m == '0;
		ex = int'(e) - 1023;
		if (ex > 127 || ex < -149)
			return 1'b0;
		if (ex >= -126) begin
			f = {d[63], 8'(ex + 127), m[51:29]};
			return m[28:0] == '0;
		end
		full = {1'b1, m};
		sh = -97 - ex;
		if ((full & ((53'd1 << sh) - 53'd1)) != '0)
			return 1'b0;
		f = f | 32'(full >> sh);
		return 1'b1;
	endfunction

	function automatic void predict_encoding(input logic [MODE_W-1:0] m, input logic [63:0] v);
		logic [31:0] f;
		item_bytes.delete();
		case (m)
			MODE_UINT: put_head(MAJOR_UINT, v);
			MODE_SINT: begin
				if (v[63])
					put_head(MAJOR_NINT, ~v);
				else
					put_head(MAJOR_UINT, v);
			end
			MODE_BOOL: item_bytes.push_back(SIMPLE_FALSE + 8'(v[0]));
			MODE_FLOAT32: begin
				item_bytes.push_back(FLOAT32_HEAD);
				put_be(v, 4);
			end
			MODE_FLOAT64: begin
				if (f64_to_f32(v, f)) begin
					item_bytes.push_back(FLOAT32_HEAD);
					put_be({32'd0, f}, 4);
				end else begin
					item_bytes.push_back(FLOAT64_HEAD);
					put_be(v, 8);
				end
			end
			MODE_BYTES: put_head(MAJOR_BYTES, v);
			MODE_TEXT: put_head(MAJOR_TEXT, v);
			MODE_MAP: put_head(MAJOR_MAP, v);
			MODE_ARRAY: put_head(MAJOR_ARRAY, v);
			MODE_PAYLOAD: item_bytes.push_back(v[7:0]);
			default: ;
		endcase
		foreach (item_bytes[i])
			expected_q.push_back('{item_bytes[i], i == item_bytes.size() - 1});
	endfunction

	function automatic void flag_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %h, actual %h", what, want, got);
	endfunction

	function automatic logic [63:0] rand_arg();
		case ($urandom_range(0, 4))
			0: return 64'($urandom_range(0, 23));
			1: return 64'($urandom_range(24, 255));
			2: return 64'($urandom_range(256, 65535));
			3: return {32'd0, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [63:0] rand_f64();
		logic [63:0] bits;
		logic [10:0] e;
		int          sh;
		bits = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return bits;
			1: begin
				e = 11'($urandom_range(EXP_F32_NORM, EXP_F32_TOP));
				bits[62:52] = e;
				if ($urandom_range(0, 3) != 0)
					bits[28:0] = '0;
				return bits;
			end
			2: begin
				e = 11'($urandom_range(EXP_F32_SUB, EXP_REBIAS));
				sh = int'(EXP_SUB_SHIFT) - int'(e);
				bits[62:52] = e;
				if ($urandom_range(0, 3) != 0)
					bits[51:0] = bits[51:0] & ~((52'd1 << sh) - 52'd1);
				return bits;
			end
			default: begin
				bits[62:52] = $urandom_range(0, 1) ? EXP_MAX : 11'd0;
				if ($urandom_range(0, 1))
					bits[51:0] = '0;
				return bits;
			end
		endcase
	endfunction

	task automatic send_item(input logic [MODE_W-1:0] m, input logic [63:0] v);
		if (!steady && $urandom_range(0, 99) < 7) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		item_valid <= 1'b1;
		mode <= m;
		value <= v;
		do @(posedge clk); while (!item_ready);
		predict_encoding(m, v);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_integer_heads();
		send_item(MODE_UINT, 64'd23);
		send_item(MODE_UINT, 64'd24);
		send_item(MODE_UINT, 64'd255);
		send_item(MODE_UINT, 64'd256);
		send_item(MODE_UINT, 64'hFFFF);
		send_item(MODE_UINT, 64'h1_0000);
		send_item(MODE_UINT, 64'hFFFF_FFFF);
		send_item(MODE_UINT, 64'h1_0000_0000);
		send_item(MODE_UINT, '1);
		send_item(MODE_SINT, '1);
		send_item(MODE_SINT, -64'sd25);
		send_item(MODE_SINT, 64'h8000_0000_0000_0000);
	endtask

	task automatic test_simple_and_floats();
		send_item(MODE_BOOL, 64'hFFFF_FFFF_FFFF_FFFE);
		send_item(MODE_BOOL, 64'h1);
		send_item(MODE_FLOAT32, 64'hDEAD_BEEF_3F80_0001);
		send_item(MODE_FLOAT64, 64'h3FF0_0000_0000_0000);
		send_item(MODE_FLOAT64, 64'h3FB9_9999_9999_999A);
		send_item(MODE_FLOAT64, 64'h7FF8_0000_0000_0000);
		send_item(MODE_FLOAT64, 64'hFFF0_0000_0000_0000);
		send_item(MODE_FLOAT64, 64'h8000_0000_0000_0000);
		send_item(MODE_FLOAT64, 64'h36A0_0000_0000_0000);
		send_item(MODE_FLOAT64, 64'h0000_0000_0000_0001);
	endtask

	task automatic test_strings_and_containers();
		send_item(MODE_BYTES, 64'd2);
		send_item(MODE_PAYLOAD, 64'hFFFF_FFFF_FFFF_FFA5);
		send_item(MODE_PAYLOAD, 64'h0);
		send_item(MODE_TEXT, 64'd300);
		send_item(MODE_MAP, 64'h1_2345_6789);
		send_item(MODE_ARRAY, 64'd0);
	endtask

	task automatic test_unused_modes();
		send_item(MODE_RESERVED_A, '1);
		send_item(MODE_RESERVED_Z, 64'd5);
		send_item(MODE_PAYLOAD, 64'h5A);
		wait_idle();
	endtask

	task automatic test_random_stream();
		int                sent;
		int                len;
		logic [MODE_W-1:0] m;
		logic [63:0]       v;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			steady = (sent >= 20 && sent < 60);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					len = $urandom_range(0, 8);
					send_item($urandom_range(0, 1) ? MODE_BYTES : MODE_TEXT, 64'(len));
					if ($urandom_range(0, 7) == 0)
						len = $urandom_range(0, len);
					repeat (len) send_item(MODE_PAYLOAD, {$urandom, $urandom});
					sent += len + 1;
				end
				4: begin
					send_item($urandom_range(0, 1) ? MODE_MAP : MODE_ARRAY, rand_arg());
					sent++;
				end
				5: begin
					send_item(MODE_FLOAT64, rand_f64());
					sent++;
				end
				6: begin
					if ($urandom_range(0, 3) == 0) begin
						send_item(MODE_RESERVED_A + 4'($urandom_range(0, 5)),
							{$urandom, $urandom});
					end else begin
						send_item(MODE_FLOAT32, {$urandom, $urandom});
						sent++;
					end
				end
				default: begin
					m = 4'($urandom_range(0, 9));
					v = rand_arg();
					if (m == MODE_SINT && $urandom_range(0, 1))
						v = ~v;
					if (m == MODE_BOOL || m == MODE_PAYLOAD)
						v = {$urandom, $urandom};
					send_item(m, v);
					sent++;
				end
			endcase
		end
		steady = 1'b0;
	endtask

	task automatic test_output_stall();
		stall_left = 300;
		steady = 1'b1;
		repeat (30) send_item(MODE_UINT, rand_arg());
		steady = 1'b0;
	endtask

	task automatic test_drain_pause();
		repeat (5) send_item(MODE_FLOAT64, rand_f64());
		wait_idle();
		repeat (5) send_item(MODE_SINT, ~rand_arg());
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			byte_ready <= 1'b0;
			stall_left--;
		end else begin
			byte_ready <= steady || $urandom_range(0, 99) >= 7;
		end
	end

	always @(posedge clk) begin
		enc_byte_t want;
		if (arst_n && byte_valid && byte_ready) begin
			if (expected_q.size() == 0) begin
				flag_mismatch("unexpected byte", 64'd0, 64'({out_byte, last_byte}));
			end else begin
				want = expected_q.pop_front();
				if (out_byte !== want.data)
					flag_mismatch("out_byte", 64'(want.data), 64'(out_byte));
				if (last_byte !== want.last)
					flag_mismatch("last_byte", 64'(want.last), 64'(last_byte));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[cbor_item_head_encoder] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_integer_heads();
		test_simple_and_floats();
		test_strings_and_containers();
		test_unused_modes();
		test_output_stall();
		test_drain_pause();
		test_random_stream();
		wait_idle();
		if (mismatches == 0 && expected_q.size() == 0)
			$display("[cbor_item_head_encoder] OK");
		else
			$display("[cbor_item_head_encoder] ERROR");
		$finish;
	end

endmodule

### sim.f
+incdir+rtl
rtl/cbih_pkg.sv
rtl/cbor_item_head_encoder.sv
tb/cbor_item_head_encoder_tb.sv
